FILE: hdl/rgba8_blend_unit_defines.svh
// Assertion macros for the verification files of the RGBA8 blend unit.
// No dependencies; include by bare file name.
`ifndef RGBA8_BLEND_UNIT_DEFINES_SVH
`define RGBA8_BLEND_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RGBAB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgba8_blend_unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RGBAB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgba8_blend_unit: next-cycle check failed");

`endif

FILE: hdl/rgbab_pkg.sv
// Package for the RGBA8 blend unit: mode codes, lane result type, channel helpers.
// No dependencies.
`default_nettype none

package rgbab_pkg;

  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned NUM_LANES = 4;
  localparam int unsigned MODE_W  = 3;

  localparam logic [MODE_W-1:0] MODE_OPAQUE      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SRC_ALPHA   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DST_ALPHA   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_TRANSPARENT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_BLEND_SRC   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_BLEND_DST   = 3'd5;
  localparam logic [MODE_W-1:0] MODE_BLEND       = 3'd6;

  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [MODE_W-1:0] mode_t;

  typedef struct packed {
    chan_t color;
    chan_t mul_d;
    chan_t s;
    chan_t d;
  } lane_out_t;

  typedef struct packed {
    logic load;
    logic take;
  } out_ctl_t;

  // floor(p / 255) for any p up to 255*255, the product of two channels
  function automatic chan_t div255(input logic [2*CHAN_W-1:0] p);
    logic [2*CHAN_W:0] t;
    t = {1'b0, p} + {{(CHAN_W+1){1'b0}}, p[2*CHAN_W-1:CHAN_W]} + {{(2*CHAN_W){1'b0}}, 1'b1};
    return t[2*CHAN_W-1:CHAN_W];
  endfunction

  function automatic chan_t avg8(input chan_t x, input chan_t y);
    logic [CHAN_W:0] sum;
    sum = {1'b0, x} + {1'b0, y};
    return sum[CHAN_W:1];
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rgbab_lane.sv
// One channel lane of the blend unit: registered products, then scaling and averaging.
// Depends on rgbab_pkg.
`default_nettype none

module rgbab_lane (
  input  wire logic               clk,
  input  wire logic               load,
  input  wire rgbab_pkg::mode_t   mode,
  input  wire rgbab_pkg::mode_t   mode_q,
  input  wire rgbab_pkg::chan_t   s,
  input  wire rgbab_pkg::chan_t   d,
  input  wire rgbab_pkg::chan_t   sa,
  input  wire rgbab_pkg::chan_t   da,
  output rgbab_pkg::lane_out_t    res
);

  logic [2*rgbab_pkg::CHAN_W-1:0] p_s_r, p_s_nxt;
  logic [2*rgbab_pkg::CHAN_W-1:0] p_d_r, p_d_nxt;
  rgbab_pkg::chan_t               s_r;
  rgbab_pkg::chan_t               d_r;
  rgbab_pkg::chan_t               xa;
  rgbab_pkg::chan_t               q_s;
  rgbab_pkg::chan_t               q_d;

  always_comb begin
    xa      = (mode == rgbab_pkg::MODE_SRC_ALPHA) ? sa : da;
    p_s_nxt = {{rgbab_pkg::CHAN_W{1'b0}}, s} * {{rgbab_pkg::CHAN_W{1'b0}}, xa};
    p_d_nxt = {{rgbab_pkg::CHAN_W{1'b0}}, d} * {{rgbab_pkg::CHAN_W{1'b0}}, sa};
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_s_r <= p_s_nxt;
      p_d_r <= p_d_nxt;
      s_r   <= s;
      d_r   <= d;
    end
  end

  always_comb begin
    q_s       = rgbab_pkg::div255(p_s_r);
    q_d       = rgbab_pkg::div255(p_d_r);
    res.mul_d = q_d;
    res.s     = s_r;
    res.d     = d_r;
    unique case (mode_q) inside
      rgbab_pkg::MODE_SRC_ALPHA, rgbab_pkg::MODE_DST_ALPHA: res.color = q_s;
      rgbab_pkg::MODE_TRANSPARENT: res.color = rgbab_pkg::avg8(s_r, d_r);
      rgbab_pkg::MODE_BLEND_SRC:   res.color = rgbab_pkg::avg8(s_r, q_d);
      rgbab_pkg::MODE_BLEND_DST:   res.color = rgbab_pkg::avg8(d_r, q_s);
      rgbab_pkg::MODE_BLEND:       res.color = rgbab_pkg::avg8(q_d, q_s);
      default:                     res.color = s_r;
    endcase
  end

endmodule

`default_nettype wire

FILE: hdl/rgbab_merge.sv
// Merging stage of the blend unit: packs lane results into a pixel and holds the output register.
// Depends on rgbab_pkg.
`default_nettype none

module rgbab_merge (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire rgbab_pkg::out_ctl_t ctl,
  input  wire rgbab_pkg::mode_t    mode_q,
  input  wire rgbab_pkg::lane_out_t lanes [rgbab_pkg::NUM_LANES],
  output logic                     out_valid,
  output logic [31:0]              out_pixel
);

  logic             valid_r, valid_nxt;
  logic [31:0]      pixel_r, pixel_nxt;
  rgbab_pkg::chan_t alpha;

  always_comb begin
    unique case (mode_q) inside
      rgbab_pkg::MODE_BLEND_SRC, rgbab_pkg::MODE_BLEND: alpha = lanes[0].mul_d;
      rgbab_pkg::MODE_SRC_ALPHA, rgbab_pkg::MODE_DST_ALPHA,
      rgbab_pkg::MODE_TRANSPARENT, rgbab_pkg::MODE_BLEND_DST: alpha = lanes[0].d;
      default: alpha = lanes[0].s;
    endcase
    pixel_nxt = {lanes[3].color, lanes[2].color, lanes[1].color, alpha};
    if (ctl.load) begin
      valid_nxt = 1'b1;
    end else if (ctl.take) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      pixel_r <= pixel_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_pixel = pixel_r;

endmodule

`default_nettype wire

FILE: hdl/rgba8_blend_unit.sv
// RGBA8 blend unit, one pixel per clock unless the output stalls: a source and a target
// pixel enter together, the four channel lanes form their 8x8 products in the first stage,
// and the second stage scales, averages and packs them into the output register. The user
// must write the blend mode register through the cfg port only while the unit is idle; the
// unit does not enforce it. Top level; depends on rgbab_pkg, rgbab_lane and rgbab_merge.
`default_nettype none

module rgba8_blend_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_blend_mode,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_source_pixel,
  input  wire logic [31:0] in_target_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_blended_pixel
);

  rgbab_pkg::mode_t     mode_r;
  rgbab_pkg::mode_t     mode_q_r;
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 o_free;
  logic                 load_s1;
  rgbab_pkg::out_ctl_t  octl;
  rgbab_pkg::lane_out_t lanes [rgbab_pkg::NUM_LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= rgbab_pkg::MODE_OPAQUE;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_blend_mode;
    end
  end

  always_comb begin
    o_free    = !out_valid || out_ready;
    in_ready  = !s1_valid_r || o_free;
    load_s1   = in_valid && in_ready;
    octl.load = s1_valid_r && o_free;
    octl.take = out_valid && out_ready;
    if (load_s1) begin
      s1_valid_nxt = 1'b1;
    end else if (octl.load) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_s1) begin
      mode_q_r <= mode_r;
    end
  end

  for (genvar ch = 0; ch < rgbab_pkg::NUM_LANES; ch++) begin : g_lane
    rgbab_lane u_lane (
      .clk    (clk),
      .load   (load_s1),
      .mode   (mode_r),
      .mode_q (mode_q_r),
      .s      (in_source_pixel[rgbab_pkg::CHAN_W*ch +: rgbab_pkg::CHAN_W]),
      .d      (in_target_pixel[rgbab_pkg::CHAN_W*ch +: rgbab_pkg::CHAN_W]),
      .sa     (in_source_pixel[rgbab_pkg::CHAN_W-1:0]),
      .da     (in_target_pixel[rgbab_pkg::CHAN_W-1:0]),
      .res    (lanes[ch])
    );
  end

  rgbab_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (octl),
    .mode_q    (mode_q_r),
    .lanes     (lanes),
    .out_valid (out_valid),
    .out_pixel (out_blended_pixel)
  );

endmodule

`default_nettype wire

FILE: hdl/rgbab_checker.sv
// Port-level checker for the RGBA8 blend unit and its bind to the top level.
// Depends on rgba8_blend_unit_defines.svh and rgba8_blend_unit.
`default_nettype none
`include "rgba8_blend_unit_defines.svh"

module rgbab_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_blended_pixel
);

  `RGBAB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_blended_pixel))
  `RGBAB_ASSERT_NOW(a_flow_ready, clk, rst_n, out_ready, in_ready)
  `RGBAB_ASSERT_NEXT(a_two_cycle, clk, rst_n, (in_valid && in_ready) ##1 out_ready, out_valid)
  `RGBAB_ASSERT_NOW(a_cfg_ready, clk, rst_n, cfg_valid, cfg_ready)

endmodule

bind rgba8_blend_unit rgbab_checker u_rgbab_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .cfg_valid         (cfg_valid),
  .cfg_ready         (cfg_ready),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_blended_pixel (out_blended_pixel)
);

`default_nettype wire
